### hdl/utrb_pkg.sv
// shared types and constants for the uart transmit/receive ring buffer block
// no dependencies

package utrb_pkg;

  // default ring depths, one slot of each ring always stays empty
  localparam int unsigned TxDepthDef = 64;
  localparam int unsigned RxDepthDef = 16;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_READ  = 2'd1,
    OP_RX_BYTE   = 2'd2,
    OP_TX_DONE   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    op_e        opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic [7:0] send_byte;
    logic       send_start;
    logic       accepted;
    logic       rx_available;
    logic       tx_full;
    logic       wake;
  } out_item_t;

endpackage

### hdl/uart_tx_rx_ring_buffers.sv
// buffered uart core: transmit ring and receive ring held in synchronous memories
// depends on utrb_pkg
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | in_valid_i / in_stall_o    | in_item_i  (in_item_t)
//  out     | output    | out_valid_o / out_stall_i  | out_item_o (out_item_t)
//
// results: write, byte received, empty read and done on an empty ring load the output register
//   directly; a read or transmit done that fetches a byte passes the memory read register first
// reset: pointers, sending flag, state and output valid clear at once; ring
//   memories are not cleared, an entry is only read after it has been written
// stalls: a held result blocks a new transfer while out_stall_i is high; a fetched
//   byte waits in the memory read register and the input stalls meanwhile

module uart_tx_rx_ring_buffers
  import utrb_pkg::*;
#(
  parameter int unsigned TX_DEPTH = TxDepthDef,
  parameter int unsigned RX_DEPTH = RxDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned TxAw = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RxAw = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam logic [TxAw-1:0] TxLast = TxAw'(TX_DEPTH - 1);
  localparam logic [RxAw-1:0] RxLast = RxAw'(RX_DEPTH - 1);

  function automatic logic [TxAw-1:0] tx_next(input logic [TxAw-1:0] p);
    return (p == TxLast) ? '0 : p + TxAw'(1);
  endfunction

  function automatic logic [RxAw-1:0] rx_next(input logic [RxAw-1:0] p);
    return (p == RxLast) ? '0 : p + RxAw'(1);
  endfunction

  // ring memories
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_mem [RX_DEPTH];

  // pointers and control state
  logic [TxAw-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d;
  logic [RxAw-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d;
  logic            sending_q, sending_d;
  state_e          state_q, state_d;
  op_e             pend_op_q, pend_op_d;

  // memory ports
  logic            tx_we, tx_re, rx_we, rx_re;
  logic [TxAw-1:0] tx_waddr, tx_raddr;
  logic [RxAw-1:0] rx_waddr, rx_raddr;
  logic [7:0]      tx_rdata_q, rx_rdata_q;

  // output register
  out_item_t out_q, res;
  logic      out_valid_q, load_out, out_free, in_acc;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // next-pointer candidates
  assign tx_waddr = tx_next(tx_wp_q);
  assign tx_raddr = tx_next(tx_rp_q);
  assign rx_waddr = rx_next(rx_wp_q);
  assign rx_raddr = rx_next(rx_rp_q);

  always_comb begin
    tx_wp_d   = tx_wp_q;
    tx_rp_d   = tx_rp_q;
    rx_wp_d   = rx_wp_q;
    rx_rp_d   = rx_rp_q;
    sending_d = sending_q;
    state_d   = state_q;
    pend_op_d = pend_op_q;
    tx_we     = 1'b0;
    tx_re     = 1'b0;
    rx_we     = 1'b0;
    rx_re     = 1'b0;
    load_out  = 1'b0;
    res       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_item_i.opcode)
            OP_CPU_WRITE: begin
              load_out = 1'b1;
              if (tx_waddr != tx_rp_q) begin
                tx_we        = 1'b1;
                tx_wp_d      = tx_waddr;
                res.accepted = 1'b1;
                // not sending means the ring was empty: the new byte goes out at once
                if (!sending_q) begin
                  sending_d      = 1'b1;
                  res.send_byte  = in_item_i.data_byte;
                  res.send_start = 1'b1;
                  tx_rp_d        = tx_waddr;
                end
              end
            end
            OP_CPU_READ: begin
              if (rx_rp_q != rx_wp_q) begin
                rx_re     = 1'b1;
                rx_rp_d   = rx_raddr;
                pend_op_d = OP_CPU_READ;
                state_d   = ST_READ;
              end else begin
                load_out = 1'b1;
              end
            end
            OP_RX_BYTE: begin
              load_out = 1'b1;
              res.wake = 1'b1;
              if (rx_waddr != rx_rp_q) begin
                rx_we        = 1'b1;
                rx_wp_d      = rx_waddr;
                res.accepted = 1'b1;
              end
            end
            OP_TX_DONE: begin
              if (tx_rp_q == tx_wp_q) begin
                sending_d = 1'b0;
                load_out  = 1'b1;
              end else begin
                tx_re     = 1'b1;
                tx_rp_d   = tx_raddr;
                pend_op_d = OP_TX_DONE;
                state_d   = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // fetched byte sits in the read register until the output is free
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (pend_op_q == OP_CPU_READ) begin
            res.read_byte  = rx_rdata_q;
            res.read_valid = 1'b1;
          end else begin
            res.send_byte  = tx_rdata_q;
            res.send_start = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // ring status after the step
    res.rx_available = (rx_rp_d != rx_wp_d);
    res.tx_full      = (tx_next(tx_wp_d) == tx_rp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wp_q     <= '0;
      tx_rp_q     <= '0;
      rx_wp_q     <= '0;
      rx_rp_q     <= '0;
      sending_q   <= 1'b0;
      state_q     <= ST_IDLE;
      pend_op_q   <= OP_CPU_READ;
      out_valid_q <= 1'b0;
    end else begin
      tx_wp_q   <= tx_wp_d;
      tx_rp_q   <= tx_rp_d;
      rx_wp_q   <= rx_wp_d;
      rx_rp_q   <= rx_rp_d;
      sending_q <= sending_d;
      state_q   <= state_d;
      pend_op_q <= pend_op_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  // transmit ring memory
  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= in_item_i.data_byte;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_raddr];
    end
  end

  // receive ring memory
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= in_item_i.data_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_raddr];
    end
  end

endmodule

### sim/tb.sv
// self-checking testbench for uart_tx_rx_ring_buffers: directed and random
// cpu / line traffic with a ring-buffer scoreboard; depends on utrb_pkg and the block

module tb
  import utrb_pkg::*;
;

  localparam int unsigned TX_DEPTH     = TxDepthDef;
  localparam int unsigned RX_DEPTH     = RxDepthDef;
  localparam int unsigned ITEM_TARGET  = 1500;
  localparam int unsigned TAIL_ITEMS   = 150;     // no idling or stalls for the last items
  localparam int unsigned DRAIN_CYCLES = 16;      // quiet drain after the last response
  localparam int unsigned LIMIT_CYCLES = 400_000; // far above the slowest legal run
  localparam int unsigned MAX_REPORTS  = 10;

  // scoreboard: shadow copy of both rings and the sending flag; every accepted
  // request yields exactly one response, kept in order until it comes out
  class uart_ring_sb;
    logic [7:0]  tx_ring [TX_DEPTH];
    logic [7:0]  rx_ring [RX_DEPTH];
    int unsigned tx_wr, tx_rd, rx_wr, rx_rd;
    bit          sending;
    out_item_t   expected_resp [$];
    int unsigned requests_seen;
    int unsigned failures;

    function new();
      tx_wr = 0;
      tx_rd = 0;
      rx_wr = 0;
      rx_rd = 0;
      sending = 1'b0;
      requests_seen = 0;
      failures = 0;
    endfunction

    function int unsigned tx_succ(int unsigned p);
      return (p + 1 >= TX_DEPTH) ? 0 : p + 1;
    endfunction

    function int unsigned rx_succ(int unsigned p);
      return (p + 1 >= RX_DEPTH) ? 0 : p + 1;
    endfunction

    // hand the next queued byte to the shifter, or end the transmission
    function void tx_pull(inout out_item_t r);
      if (tx_rd == tx_wr) begin
        sending = 1'b0;
      end else begin
        tx_rd = tx_succ(tx_rd);
        r.send_byte  = tx_ring[tx_rd];
        r.send_start = 1'b1;
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t   r;
      int unsigned n;
      r = '0;
      case (req.opcode)
        OP_CPU_WRITE: begin
          n = tx_succ(tx_wr);
          // full transmit ring drops the byte and changes nothing
          if (n != tx_rd) begin
            tx_ring[n] = req.data_byte;
            tx_wr = n;
            r.accepted = 1'b1;
            if (!sending) begin
              sending = 1'b1;
              tx_pull(r);
            end
          end
        end
        OP_CPU_READ: begin
          // empty receive ring leaves read_valid and read_byte at zero
          if (rx_rd != rx_wr) begin
            rx_rd = rx_succ(rx_rd);
            r.read_byte  = rx_ring[rx_rd];
            r.read_valid = 1'b1;
          end
        end
        OP_RX_BYTE: begin
          n = rx_succ(rx_wr);
          if (n != rx_rd) begin
            rx_ring[n] = req.data_byte;
            rx_wr = n;
            r.accepted = 1'b1;
          end
          // wake rises even when the byte is dropped
          r.wake = 1'b1;
        end
        default: begin
          // transmit done, also while idle
          tx_pull(r);
        end
      endcase
      r.rx_available = (rx_rd != rx_wr);
      r.tx_full      = (tx_succ(tx_wr) == tx_rd);
      expected_resp.push_back(r);
      requests_seen++;
    endfunction

    function string show(out_item_t r);
      return $sformatf({"rd_byte=%h rd_valid=%b send=%h start=%b ",
                        "acc=%b rx_av=%b tx_full=%b wake=%b"},
                       r.read_byte, r.read_valid, r.send_byte, r.send_start,
                       r.accepted, r.rx_available, r.tx_full, r.wake);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      bit        bad;
      if (expected_resp.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected response: %s", show(got));
      end else begin
        want = expected_resp.pop_front();
        bad = (got.read_byte    !== want.read_byte)    ||
              (got.read_valid   !== want.read_valid)   ||
              (got.send_byte    !== want.send_byte)    ||
              (got.send_start   !== want.send_start)   ||
              (got.accepted     !== want.accepted)     ||
              (got.rx_available !== want.rx_available) ||
              (got.tx_full      !== want.tx_full)      ||
              (got.wake         !== want.wake);
        if (bad) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  in_item_t    stim_q [$];
  int unsigned stim_total;
  logic        tail_phase = 1'b0;
  int unsigned cycle_count;
  uart_ring_sb ring_sb;

  uart_tx_rx_ring_buffers u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void add_item(op_e op, logic [7:0] d);
    in_item_t it;
    it.opcode    = op;
    it.data_byte = d;
    stim_q.push_back(it);
  endfunction

  // opcode from percentage weights: write, read, receive, rest is transmit done
  function automatic op_e pick_op(int unsigned w_wr, int unsigned w_rd, int unsigned w_rx);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_wr) return OP_CPU_WRITE;
    if (r < w_wr + w_rd) return OP_CPU_READ;
    if (r < w_wr + w_rd + w_rx) return OP_RX_BYTE;
    return OP_TX_DONE;
  endfunction

  task automatic build_stimulus();
    int unsigned kind;
    int unsigned len;
    op_e         op;
    // directed: empty read, done while idle, start of transmission, queued
    // bytes, end of transmission, receive and read back, extremes of data
    add_item(OP_CPU_READ,  8'hff);
    add_item(OP_TX_DONE,   8'h00);
    add_item(OP_CPU_WRITE, 8'h00);
    add_item(OP_CPU_WRITE, 8'hff);
    add_item(OP_CPU_WRITE, 8'h5a);
    add_item(OP_TX_DONE,   8'hff);
    add_item(OP_TX_DONE,   8'h00);
    add_item(OP_TX_DONE,   8'h00);
    add_item(OP_TX_DONE,   8'hff);
    add_item(OP_RX_BYTE,   8'h00);
    add_item(OP_RX_BYTE,   8'hff);
    add_item(OP_RX_BYTE,   8'ha5);
    add_item(OP_CPU_READ,  8'h00);
    add_item(OP_CPU_READ,  8'hff);
    add_item(OP_CPU_READ,  8'h00);
    add_item(OP_CPU_READ,  8'h00);
    add_item(OP_CPU_WRITE, 8'h80);
    add_item(OP_RX_BYTE,   8'h01);
    add_item(OP_CPU_READ,  8'hff);
    add_item(OP_TX_DONE,   8'h00);
    add_item(OP_TX_DONE,   8'h00);

    // random phases: mixed traffic, or runs that fill or drain one ring so
    // that full and empty are reached again and again with random contents
    while (stim_q.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 4);
      len  = (kind == 1 || kind == 3) ? $urandom_range(60, 100) : $urandom_range(8, 60);
      for (int unsigned i = 0; i < len && stim_q.size() < ITEM_TARGET; i++) begin
        case (kind)
          0:       op = pick_op(25, 25, 25); // mixed
          1:       op = pick_op(90,  3,  2); // fill the transmit ring
          2:       op = pick_op(10,  5,  5); // drain the transmit ring
          3:       op = pick_op( 3,  5, 85); // fill the receive ring
          default: op = pick_op( 5, 80, 10); // drain the receive ring
        endcase
        add_item(op, 8'($urandom_range(0, 255)));
      end
    end
    stim_total = stim_q.size();
  endtask

  // sender: a new item goes out only when the slot is free (nothing presented,
  // or the current item transfers at this edge); idle bursts start at random outside the tail phase
  task automatic run_sender();
    int unsigned idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        tail_phase <= (stim_q.size() < TAIL_ITEMS);
        if (!in_valid_i || !in_stall_o) begin
          if (idle_left > 0) begin
            idle_left--;
            in_valid_i <= 1'b0;
          end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
            idle_left = $urandom_range(1, 16) - 1;
            in_valid_i <= 1'b0;
          end else if (stim_q.size() > 0) begin
            in_item_i  <= stim_q.pop_front();
            in_valid_i <= 1'b1;
          end else begin
            in_valid_i <= 1'b0;
          end
        end
      end
    end
  endtask

  // receiver: stall bursts start at random outside the tail phase, independent of out_valid_o
  task automatic run_receiver();
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rst_ni && !tail_phase && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  endtask

  initial run_sender();
  initial run_receiver();

  // monitor: the request transfer is noted before the response of the same
  // edge is checked, so a same-edge answer would still find its expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) ring_sb.note_request(in_item_i);
      if (out_valid_o && !out_stall_i) ring_sb.check_response(out_item_o);
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** uart_tx_rx_ring_buffers: FAILED **");
    $finish;
  end

  initial begin
    ring_sb = new();
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // every request transferred, every response seen, then a quiet drain
    while (ring_sb.requests_seen < stim_total) @(posedge clk_i);
    while (ring_sb.expected_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ring_sb.failures == 0 && ring_sb.expected_resp.size() == 0) begin
      $display("** uart_tx_rx_ring_buffers: PASSED **");
    end else begin
      $display("** uart_tx_rx_ring_buffers: FAILED **");
    end
    $finish;
  end

endmodule

### uart_tx_rx_ring_buffers.f
hdl/utrb_pkg.sv
hdl/uart_tx_rx_ring_buffers.sv
sim/tb.sv
